// ===== rtl/dspp_pkg.sv =====
// Package for the depth surface paint pixel core: command and register codes,
// field widths, fixed-point constants and the structs passed between stages.
// No dependencies.
package dspp_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_LIVE = 2'd0,
      CMD_LOAD_BG   = 2'd1,
      CMD_RENDER    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_C0_X = 3'd0,
      REG_C0_Y = 3'd1,
      REG_C1_X = 3'd2,
      REG_C1_Y = 3'd3,
      REG_C2_X = 3'd4,
      REG_C2_Y = 3'd5,
      REG_C3_X = 3'd6,
      REG_C3_Y = 3'd7
   } reg_index_type;

   // field widths
   localparam int CMD_W    = 2;
   localparam int DIDX_W   = 19;
   localparam int DVAL_W   = 16;
   localparam int SCR_W    = 10;
   localparam int SIDX_W   = 20;
   localparam int GREY_W   = 8;
   localparam int COORD_W  = 12;
   localparam int REGIDX_W = 3;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   // weights are Q16, products of two weights Q32
   localparam int FRAC_W       = 16;
   localparam int WEIGHT_W     = 2 * FRAC_W + 1;
   localparam int PROD_W       = 46;
   localparam int RECIP_SHIFT  = 38;
   localparam int RECIP_W      = 38;
   localparam int RECIP_PROD_W = 48;

   // grey ramp: (delta-30)*255/120 == (delta-30)*17/8
   localparam int DELTA_W     = 17;
   localparam int DELTA_MIN   = 30;
   localparam int DELTA_MAX   = 150;
   localparam int SPAN_W      = 7;
   localparam int GREY_MUL    = 17;
   localparam int GREY_SHIFT  = 3;
   localparam int GREY_PROD_W = 11;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type [3:0] x;
      coord_type [3:0] y;
   } corner_set_type;

   localparam corner_set_type CORNER_RESET = '{
      x: {12'd0,   12'd639, 12'd639, 12'd0},
      y: {12'd479, 12'd479, 12'd0,   12'd0}
   };

   typedef struct packed {
      logic    valid;
      cmd_type op;
      logic    hit;
   } warp_ctrl_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } fetch_ctrl_type;

endpackage

// ===== rtl/dspp_csr.sv =====
// Corner point registers of the depth surface paint pixel core.
// Uses dspp_pkg for register codes, coordinate type and reset values.
module dspp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_valid,
   output logic                             wr_ready,
   input  logic [dspp_pkg::REGIDX_W-1:0]    wr_index,
   input  logic [dspp_pkg::COORD_W-1:0]     wr_data,
   output dspp_pkg::corner_set_type         corners
);

   dspp_pkg::corner_set_type corners_ff;

   assign wr_ready = 1'b1;
   assign corners  = corners_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corners_ff <= dspp_pkg::CORNER_RESET;
      end else if (wr_valid) begin
         case (dspp_pkg::reg_index_type'(wr_index))
            dspp_pkg::REG_C0_X: begin
               corners_ff.x[0] <= wr_data;
            end
            dspp_pkg::REG_C0_Y: begin
               corners_ff.y[0] <= wr_data;
            end
            dspp_pkg::REG_C1_X: begin
               corners_ff.x[1] <= wr_data;
            end
            dspp_pkg::REG_C1_Y: begin
               corners_ff.y[1] <= wr_data;
            end
            dspp_pkg::REG_C2_X: begin
               corners_ff.x[2] <= wr_data;
            end
            dspp_pkg::REG_C2_Y: begin
               corners_ff.y[2] <= wr_data;
            end
            dspp_pkg::REG_C3_X: begin
               corners_ff.x[3] <= wr_data;
            end
            dspp_pkg::REG_C3_Y: begin
               corners_ff.y[3] <= wr_data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/dspp_warp.sv =====
// Six-stage front end: screen clamp, Q16 weights, bilinear blend of the corners,
// truncation, frame check and depth address. Loads ride along to keep order.
// Uses dspp_pkg.
module dspp_warp #(
   parameter int SCREEN_W = 1024,
   parameter int SCREEN_H = 768,
   parameter int DEPTH_W  = 640,
   parameter int DEPTH_H  = 480,
   parameter int ADDR_W   = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dspp_pkg::cmd_type             in_cmd,
   input  logic [dspp_pkg::DIDX_W-1:0]   in_depth_index,
   input  logic [dspp_pkg::DVAL_W-1:0]   in_depth_value,
   input  logic [dspp_pkg::SCR_W-1:0]    in_screen_x,
   input  logic [dspp_pkg::SCR_W-1:0]    in_screen_y,
   input  dspp_pkg::corner_set_type      corners,
   output dspp_pkg::warp_ctrl_type       out_ctrl,
   input  logic                          out_ready,
   output logic [ADDR_W-1:0]             out_addr,
   output logic [dspp_pkg::DVAL_W-1:0]   out_depth_value,
   output logic [dspp_pkg::SIDX_W-1:0]   out_screen_index
);

   localparam int STAGES   = 6;
   localparam int SCR_W    = dspp_pkg::SCR_W;
   localparam int DVAL_W   = dspp_pkg::DVAL_W;
   localparam int SIDX_W   = dspp_pkg::SIDX_W;
   localparam int FRAC_W   = dspp_pkg::FRAC_W;
   localparam int WEIGHT_W = dspp_pkg::WEIGHT_W;
   localparam int PROD_W   = dspp_pkg::PROD_W;
   localparam int COORD_W  = dspp_pkg::COORD_W;
   localparam int RPROD_W  = dspp_pkg::RECIP_PROD_W;
   localparam int RSHIFT   = dspp_pkg::RECIP_SHIFT;
   localparam int LIM_W    = 13;
   localparam int SIDX_FULL_W = 24;
   localparam int AMUL_W   = 24;
   localparam int Q32      = 2 * FRAC_W;
   localparam int UCOORD_W = COORD_W - 1;
   localparam int unsigned DEPTH_N = DEPTH_W * DEPTH_H;
   localparam longint unsigned RECIP_X =
      ((64'd1 << RSHIFT) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W);
   localparam longint unsigned RECIP_Y =
      ((64'd1 << RSHIFT) + 64'(SCREEN_H) - 64'd1) / 64'(SCREEN_H);
   localparam logic [FRAC_W:0] ONE_Q = (FRAC_W + 1)'(1) << FRAC_W;
   localparam logic [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) << Q32) - PROD_W'(1);

   logic [STAGES-1:0]          vld_ff;
   logic [STAGES-1:0]          en;
   dspp_pkg::cmd_type          op_ff   [STAGES];
   logic                       hit_ff  [STAGES];
   logic [DVAL_W-1:0]          dval_ff [STAGES];
   logic [SIDX_W-1:0]          sidx_ff [STAGES];
   logic [ADDR_W-1:0]          addr_ff [STAGES];

   logic [SCR_W-1:0]           sx_lim, sy_lim;
   logic [RPROD_W-1:0]         recx_in, recy_in, recx_ff, recy_ff;
   logic [SIDX_W-1:0]          sidx_in;
   logic                       load_ok_in;
   logic                       cmd_ok;

   logic [FRAC_W-1:0]          wa, wb;
   logic [FRAC_W:0]            wna, wnb;
   logic [WEIGHT_W-1:0]        w_in [4];
   logic [WEIGHT_W-1:0]        w_ff [4];

   logic signed [PROD_W-1:0]   prodx_in [4];
   logic signed [PROD_W-1:0]   prody_in [4];
   logic signed [PROD_W-1:0]   prodx_ff [4];
   logic signed [PROD_W-1:0]   prody_ff [4];

   logic signed [PROD_W-1:0]   sumx_in, sumy_in, sumx_ff, sumy_ff;

   logic signed [PROD_W-1:0]   biasx_sum, biasy_sum;
   logic [COORD_W-1:0]         ptx, pty;
   logic                       hit4_in;
   logic [UCOORD_W-1:0]        pxu_ff, pyu_ff;

   logic [ADDR_W-1:0]          addr5_in;

   // ready chain: a stage takes a new request when empty or when it moves on
   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   // stage 0: clamp, reciprocal products, screen index, load range check
   always_comb begin
      cmd_ok = (in_cmd == dspp_pkg::CMD_LOAD_LIVE) || (in_cmd == dspp_pkg::CMD_LOAD_BG)
            || (in_cmd == dspp_pkg::CMD_RENDER);
      sx_lim = (LIM_W'(in_screen_x) > LIM_W'(SCREEN_W - 1)) ? SCR_W'(SCREEN_W - 1)
                                                             : in_screen_x;
      sy_lim = (LIM_W'(in_screen_y) > LIM_W'(SCREEN_H - 1)) ? SCR_W'(SCREEN_H - 1)
                                                             : in_screen_y;
      recx_in = RPROD_W'(sx_lim) * RPROD_W'(RECIP_X);
      recy_in = RPROD_W'(sy_lim) * RPROD_W'(RECIP_Y);
      sidx_in = SIDX_W'(SIDX_FULL_W'(sy_lim) * SIDX_FULL_W'(SCREEN_W)
                        + SIDX_FULL_W'(sx_lim));
      load_ok_in = 32'(in_depth_index) < DEPTH_N;
   end

   // stage 1: weight products
   always_comb begin
      wa  = recx_ff[RSHIFT-1 -: FRAC_W];
      wb  = recy_ff[RSHIFT-1 -: FRAC_W];
      wna = ONE_Q - (FRAC_W + 1)'(wa);
      wnb = ONE_Q - (FRAC_W + 1)'(wb);
      w_in[0] = WEIGHT_W'(wna) * WEIGHT_W'(wnb);
      w_in[1] = WEIGHT_W'(wa)  * WEIGHT_W'(wnb);
      w_in[2] = WEIGHT_W'(wa)  * WEIGHT_W'(wb);
      w_in[3] = WEIGHT_W'(wna) * WEIGHT_W'(wb);
   end

   // stage 2: weight times corner
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prodx_in[i] = PROD_W'($signed({1'b0, w_ff[i]})) * PROD_W'($signed(corners.x[i]));
         prody_in[i] = PROD_W'($signed({1'b0, w_ff[i]})) * PROD_W'($signed(corners.y[i]));
      end
   end

   // stage 3: Q32 sums
   assign sumx_in = prodx_ff[0] + prodx_ff[1] + prodx_ff[2] + prodx_ff[3];
   assign sumy_in = prody_ff[0] + prody_ff[1] + prody_ff[2] + prody_ff[3];

   // stage 4: truncate toward zero, frame check
   always_comb begin
      biasx_sum = sumx_ff + (sumx_ff[PROD_W-1] ? $signed(TRUNC_BIAS) : PROD_W'(0));
      biasy_sum = sumy_ff + (sumy_ff[PROD_W-1] ? $signed(TRUNC_BIAS) : PROD_W'(0));
      ptx = biasx_sum[Q32 +: COORD_W];
      pty = biasy_sum[Q32 +: COORD_W];
      if (op_ff[3] == dspp_pkg::CMD_RENDER) begin
         hit4_in = !ptx[COORD_W-1] && !pty[COORD_W-1]
                && (LIM_W'(ptx[UCOORD_W-1:0]) < LIM_W'(DEPTH_W))
                && (LIM_W'(pty[UCOORD_W-1:0]) < LIM_W'(DEPTH_H));
      end else begin
         hit4_in = hit_ff[3];
      end
   end

   // stage 5: depth address
   always_comb begin
      if (op_ff[4] == dspp_pkg::CMD_RENDER) begin
         addr5_in = ADDR_W'(AMUL_W'(pyu_ff) * AMUL_W'(DEPTH_W) + AMUL_W'(pxu_ff));
      end else begin
         addr5_in = addr_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid && cmd_ok;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op_ff[0]   <= in_cmd;
         hit_ff[0]  <= load_ok_in;
         dval_ff[0] <= in_depth_value;
         sidx_ff[0] <= sidx_in;
         addr_ff[0] <= ADDR_W'(in_depth_index);
         recx_ff    <= recx_in;
         recy_ff    <= recy_in;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            op_ff[k]   <= op_ff[k-1];
            dval_ff[k] <= dval_ff[k-1];
            sidx_ff[k] <= sidx_ff[k-1];
         end
      end
      for (int k = 1; k < STAGES - 1; k++) begin
         if (en[k]) begin
            addr_ff[k] <= addr_ff[k-1];
         end
      end
      if (en[1]) begin
         hit_ff[1] <= hit_ff[0];
         w_ff      <= w_in;
      end
      if (en[2]) begin
         hit_ff[2] <= hit_ff[1];
         prodx_ff  <= prodx_in;
         prody_ff  <= prody_in;
      end
      if (en[3]) begin
         hit_ff[3] <= hit_ff[2];
         sumx_ff   <= sumx_in;
         sumy_ff   <= sumy_in;
      end
      if (en[4]) begin
         hit_ff[4] <= hit4_in;
         pxu_ff    <= ptx[UCOORD_W-1:0];
         pyu_ff    <= pty[UCOORD_W-1:0];
      end
      if (en[5]) begin
         hit_ff[5]  <= hit_ff[4];
         addr_ff[5] <= addr5_in;
      end
   end

   assign out_ctrl.valid   = vld_ff[STAGES-1];
   assign out_ctrl.op      = op_ff[STAGES-1];
   assign out_ctrl.hit     = hit_ff[STAGES-1];
   assign out_addr         = addr_ff[STAGES-1];
   assign out_depth_value  = dval_ff[STAGES-1];
   assign out_screen_index = sidx_ff[STAGES-1];

endmodule

// ===== rtl/dspp_store.sv =====
// Live and background depth frame memories: one write or one read per request,
// registered read data. Loads end here; renders carry both depths onward.
// Uses dspp_pkg.
module dspp_store #(
   parameter int ADDR_W  = 19,
   parameter int DEPTH_N = 307200
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dspp_pkg::warp_ctrl_type       in_ctrl,
   output logic                          in_ready,
   input  logic [ADDR_W-1:0]             in_addr,
   input  logic [dspp_pkg::DVAL_W-1:0]   in_depth_value,
   input  logic [dspp_pkg::SIDX_W-1:0]   in_screen_index,
   output dspp_pkg::fetch_ctrl_type      out_ctrl,
   input  logic                          out_ready,
   output logic [dspp_pkg::DVAL_W-1:0]   out_live,
   output logic [dspp_pkg::DVAL_W-1:0]   out_bg,
   output logic [dspp_pkg::SIDX_W-1:0]   out_screen_index
);

   localparam int DVAL_W = dspp_pkg::DVAL_W;

   logic [DVAL_W-1:0]            live_mem [DEPTH_N];
   logic [DVAL_W-1:0]            bg_mem   [DEPTH_N];

   logic                         en, take, wr_live, wr_bg, rd;
   logic                         vld_ff, hit_ff;
   logic [DVAL_W-1:0]            live_ff, bg_ff;
   logic [dspp_pkg::SIDX_W-1:0]  sidx_ff;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;
   assign take     = en && in_ctrl.valid;
   assign wr_live  = take && in_ctrl.hit && (in_ctrl.op == dspp_pkg::CMD_LOAD_LIVE);
   assign wr_bg    = take && in_ctrl.hit && (in_ctrl.op == dspp_pkg::CMD_LOAD_BG);
   assign rd       = take && in_ctrl.hit && (in_ctrl.op == dspp_pkg::CMD_RENDER);

   always_ff @(posedge clock) begin
      if (wr_live) begin
         live_mem[in_addr] <= in_depth_value;
      end
      if (rd) begin
         live_ff <= live_mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_bg) begin
         bg_mem[in_addr] <= in_depth_value;
      end
      if (rd) begin
         bg_ff <= bg_mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_ctrl.valid && (in_ctrl.op == dspp_pkg::CMD_RENDER);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= in_ctrl.hit;
         sidx_ff <= in_screen_index;
      end
   end

   assign out_ctrl.valid   = vld_ff;
   assign out_ctrl.hit     = hit_ff;
   assign out_live         = live_ff;
   assign out_bg           = bg_ff;
   assign out_screen_index = sidx_ff;

endmodule

// ===== rtl/dspp_shade.sv =====
// Two-stage back end: depth difference and window test, then the grey ramp.
// Its second stage is the result register. Uses dspp_pkg.
module dspp_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  dspp_pkg::fetch_ctrl_type      in_ctrl,
   output logic                          in_ready,
   input  logic [dspp_pkg::DVAL_W-1:0]   in_live,
   input  logic [dspp_pkg::DVAL_W-1:0]   in_bg,
   input  logic [dspp_pkg::SIDX_W-1:0]   in_screen_index,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [dspp_pkg::GREY_W-1:0]   out_pixel_value,
   output logic                          out_pixel_written,
   output logic [dspp_pkg::SIDX_W-1:0]   out_screen_index
);

   localparam int DELTA_W = dspp_pkg::DELTA_W;
   localparam int SPAN_W  = dspp_pkg::SPAN_W;
   localparam int GPW     = dspp_pkg::GREY_PROD_W;
   localparam int GREY_W  = dspp_pkg::GREY_W;
   localparam int SIDX_W  = dspp_pkg::SIDX_W;

   logic [1:0]                 vld_ff;
   logic                       en0, en1;
   logic signed [DELTA_W-1:0]  delta;
   logic                       ok_in, ok_ff;
   logic [SPAN_W-1:0]          span_in, span_ff;
   logic [SIDX_W-1:0]          sidx_ff;
   logic [GPW-1:0]             grey;
   logic [GREY_W-1:0]          value_in, value_ff;
   logic                       written_ff;
   logic [SIDX_W-1:0]          out_sidx_ff;

   assign en1      = !vld_ff[1] || out_ready;
   assign en0      = !vld_ff[0] || en1;
   assign in_ready = en0;

   always_comb begin
      delta   = $signed({1'b0, in_bg}) - $signed({1'b0, in_live});
      ok_in   = in_ctrl.hit && (in_live != '0) && (in_bg != '0)
             && (delta >= dspp_pkg::DELTA_MIN) && (delta <= dspp_pkg::DELTA_MAX);
      span_in = SPAN_W'(delta - DELTA_W'(dspp_pkg::DELTA_MIN));
   end

   always_comb begin
      grey     = GPW'(span_ff) * GPW'(dspp_pkg::GREY_MUL);
      value_in = ok_ff ? GREY_W'(grey >> dspp_pkg::GREY_SHIFT) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en0) begin
            vld_ff[0] <= in_ctrl.valid;
         end
         if (en1) begin
            vld_ff[1] <= vld_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         ok_ff   <= ok_in;
         span_ff <= span_in;
         sidx_ff <= in_screen_index;
      end
      if (en1) begin
         value_ff    <= value_in;
         written_ff  <= ok_ff;
         out_sidx_ff <= sidx_ff;
      end
   end

   assign out_valid         = vld_ff[1];
   assign out_pixel_value   = value_ff;
   assign out_pixel_written = written_ff;
   assign out_screen_index  = out_sidx_ff;

endmodule

// ===== rtl/depth_surface_paint_pixel_core.sv =====
// Depth surface paint pixel core, top level: request/result streams, corner
// registers and the warp, store and shade pipeline. Uses dspp_pkg.
//
// Takes one request per clock while req_tready is high and presents each render
// result from its result register once it has passed every register stage; loads
// (cmd 0 live, 1 background) give no result and cmd 3 is dropped. The nine
// register stages are: clamp and weight reciprocals, weight products, corner
// products, sums, truncation and frame check, depth address, frame memory
// access, depth difference, grey ramp and result register. Each frame memory
// is DEPTH_W*DEPTH_H words of 16 bits with one write or one read per cycle at
// the memory stage, so a render right behind a load of the same pixel already
// sees the new depth. Memory contents are undefined until loaded. Stages fill
// bubbles when the result side stalls; req_tready falls only when every stage
// holds a request and the result is not being taken. The user must write the
// corner registers through the csr port only while the pipe is empty; not enforced.
module depth_surface_paint_pixel_core #(
   parameter int SCREEN_W = 1024,
   parameter int SCREEN_H = 768,
   parameter int DEPTH_W  = 640,
   parameter int DEPTH_H  = 480
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [18:0] depth_index, [34:19] depth_value, [44:35] screen_x,
   // [54:45] screen_y, [55] zero
   input  logic [dspp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  logic [dspp_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] pixel_value, [27:8] screen_index, [31:28] zero
   output logic [dspp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] pixel_written
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dspp_pkg::REGIDX_W-1:0]     csr_index,
   input  logic [dspp_pkg::COORD_W-1:0]      csr_data
);

   localparam int unsigned DEPTH_N = DEPTH_W * DEPTH_H;
   localparam int ADDR_W   = $clog2(DEPTH_N);
   localparam int DIDX_W   = dspp_pkg::DIDX_W;
   localparam int DVAL_W   = dspp_pkg::DVAL_W;
   localparam int SCR_W    = dspp_pkg::SCR_W;
   localparam int SIDX_W   = dspp_pkg::SIDX_W;
   localparam int GREY_W   = dspp_pkg::GREY_W;
   localparam int DVAL_LO  = DIDX_W;
   localparam int SX_LO    = DVAL_LO + DVAL_W;
   localparam int SY_LO    = SX_LO + SCR_W;
   localparam int RSP_PAD_W = dspp_pkg::RSP_DATA_W - GREY_W - SIDX_W;

   dspp_pkg::corner_set_type   corners;
   dspp_pkg::warp_ctrl_type    warp_ctrl;
   dspp_pkg::fetch_ctrl_type   fetch_ctrl;
   logic                       store_ready, shade_ready;
   logic [ADDR_W-1:0]          warp_addr;
   logic [DVAL_W-1:0]          warp_dval;
   logic [SIDX_W-1:0]          warp_sidx, fetch_sidx, rsp_sidx;
   logic [DVAL_W-1:0]          fetch_live, fetch_bg;
   logic [GREY_W-1:0]          rsp_value;

   dspp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_valid),
      .wr_ready (csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .corners  (corners)
   );

   dspp_warp #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H),
      .DEPTH_W  (DEPTH_W),
      .DEPTH_H  (DEPTH_H),
      .ADDR_W   (ADDR_W)
   ) u_warp (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_cmd           (dspp_pkg::cmd_type'(req_tuser)),
      .in_depth_index   (req_tdata[DIDX_W-1:0]),
      .in_depth_value   (req_tdata[DVAL_LO +: DVAL_W]),
      .in_screen_x      (req_tdata[SX_LO +: SCR_W]),
      .in_screen_y      (req_tdata[SY_LO +: SCR_W]),
      .corners          (corners),
      .out_ctrl         (warp_ctrl),
      .out_ready        (store_ready),
      .out_addr         (warp_addr),
      .out_depth_value  (warp_dval),
      .out_screen_index (warp_sidx)
   );

   dspp_store #(
      .ADDR_W  (ADDR_W),
      .DEPTH_N (DEPTH_N)
   ) u_store (
      .clock            (clock),
      .reset            (reset),
      .in_ctrl          (warp_ctrl),
      .in_ready         (store_ready),
      .in_addr          (warp_addr),
      .in_depth_value   (warp_dval),
      .in_screen_index  (warp_sidx),
      .out_ctrl         (fetch_ctrl),
      .out_ready        (shade_ready),
      .out_live         (fetch_live),
      .out_bg           (fetch_bg),
      .out_screen_index (fetch_sidx)
   );

   dspp_shade u_shade (
      .clock             (clock),
      .reset             (reset),
      .in_ctrl           (fetch_ctrl),
      .in_ready          (shade_ready),
      .in_live           (fetch_live),
      .in_bg             (fetch_bg),
      .in_screen_index   (fetch_sidx),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_pixel_value   (rsp_value),
      .out_pixel_written (rsp_tuser),
      .out_screen_index  (rsp_sidx)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), rsp_sidx, rsp_value};

`ifndef SYNTH
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_stall_from_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a held result");

   a_unwritten_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_value == '0))
      else $error("grey value set on an unwritten pixel");

   a_index_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((SCREEN_W * SCREEN_H > (1 << SIDX_W))
                      || (32'(rsp_sidx) < SCREEN_W * SCREEN_H)))
      else $error("screen index beyond the screen");
`endif

endmodule

// ===== sim/tb_depth_surface_paint_pixel_core.sv =====
// Self-checking testbench for depth_surface_paint_pixel_core: loads live and
// background depth, renders screen pixels through several corner quads and
// checks each paint result against an in-bench warp and shade predictor.
// Depends on rtl/dspp_pkg.sv and rtl/depth_surface_paint_pixel_core.sv.
`timescale 1ns / 100ps

module tb_depth_surface_paint_pixel_core;

   localparam int CMD_W      = dspp_pkg::CMD_W;
   localparam int DIDX_W     = dspp_pkg::DIDX_W;
   localparam int DVAL_W     = dspp_pkg::DVAL_W;
   localparam int SCR_W      = dspp_pkg::SCR_W;
   localparam int SIDX_W     = dspp_pkg::SIDX_W;
   localparam int GREY_W     = dspp_pkg::GREY_W;
   localparam int COORD_W    = dspp_pkg::COORD_W;
   localparam int REGIDX_W   = dspp_pkg::REGIDX_W;
   localparam int REQ_DATA_W = dspp_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = dspp_pkg::RSP_DATA_W;
   localparam int DELTA_MIN  = dspp_pkg::DELTA_MIN;
   localparam int DELTA_MAX  = dspp_pkg::DELTA_MAX;

   localparam int SCREEN_W = 1024;
   localparam int SCREEN_H = 768;
   localparam int DEPTH_W  = 640;
   localparam int DEPTH_H  = 480;
   localparam int DEPTH_N  = DEPTH_W * DEPTH_H;
   localparam int GREY_FULL    = 255;
   localparam int PIPE_FLUSH   = 12;
   localparam int PHASE_ITEMS  = 260;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam longint Q16_ONE  = 64'sd65536;
   localparam longint Q32_ONE  = 64'sd4294967296;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DIDX_W-1:0] depth_index;
      logic [DVAL_W-1:0] depth_value;
      logic [SCR_W-1:0]  screen_x;
      logic [SCR_W-1:0]  screen_y;
   } paint_request_type;

   typedef struct packed {
      logic [GREY_W-1:0] grey;
      logic              written;
      logic [SIDX_W-1:0] screen_index;
   } paint_result_type;

   typedef struct packed {
      logic [SCR_W-1:0] x;
      logic [SCR_W-1:0] y;
   } screen_pixel_type;

   localparam int REQ_BITS = $bits(paint_request_type);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [REGIDX_W-1:0]   csr_index = '0;
   logic [COORD_W-1:0]    csr_data = '0;

   depth_surface_paint_pixel_core #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H),
      .DEPTH_W (DEPTH_W),
      .DEPTH_H (DEPTH_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   dspp_pkg::corner_set_type warp_corners = dspp_pkg::CORNER_RESET;
   logic [DVAL_W-1:0] live_depth [DEPTH_N];
   logic [DVAL_W-1:0] bg_depth [DEPTH_N];
   bit                live_loaded [DEPTH_N];
   bit                bg_loaded [DEPTH_N];
   paint_result_type  expected_paints [$];
   screen_pixel_type  recent_pixels [$];

   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   int failures        = 0;
   int phase_items     = 0;
   int load_count      = 0;
   int render_count    = 0;
   int painted_count   = 0;
   int ignored_count   = 0;
   int quad_count      = 0;
   int cycle_count     = 0;
   int stall_left      = 0;

   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 24);
      return $urandom_range(1, 3);
   endfunction

   function automatic int sender_gap();
      if (!sender_gaps || $urandom_range(0, 99) < 60)
         return 0;
      return idle_length();
   endfunction

   // bilinear blend of one axis, Q32 sum truncated toward zero
   function automatic longint warp_axis(input longint a, input longint b,
                                        input dspp_pkg::coord_type [3:0] c);
      longint na, nb, s;
      na = Q16_ONE - a;
      nb = Q16_ONE - b;
      s = na * nb * longint'($signed(c[0])) + a * nb * longint'($signed(c[1]))
        + a * b * longint'($signed(c[2])) + na * b * longint'($signed(c[3]));
      return s / Q32_ONE;
   endfunction

   function automatic logic map_point(input logic [SCR_W-1:0] sx_raw,
                                      input logic [SCR_W-1:0] sy_raw,
                                      output logic [DIDX_W-1:0] idx,
                                      output logic [SIDX_W-1:0] sidx);
      longint sx, sy, px, py;
      sx = (sx_raw > SCREEN_W - 1) ? SCREEN_W - 1 : sx_raw;
      sy = (sy_raw > SCREEN_H - 1) ? SCREEN_H - 1 : sy_raw;
      px = warp_axis((sx << 16) / SCREEN_W, (sy << 16) / SCREEN_H, warp_corners.x);
      py = warp_axis((sx << 16) / SCREEN_W, (sy << 16) / SCREEN_H, warp_corners.y);
      sidx = SIDX_W'(sx + SCREEN_W * sy);
      idx = '0;
      if (px >= 0 && px < DEPTH_W && py >= 0 && py < DEPTH_H) begin
         idx = DIDX_W'(px + DEPTH_W * py);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic shade_request(input paint_request_type r);
      paint_result_type res;
      logic [DIDX_W-1:0] idx;
      int delta;
      case (r.cmd)
         dspp_pkg::CMD_LOAD_LIVE: begin
            if (r.depth_index < DEPTH_N) begin
               live_depth[r.depth_index] = r.depth_value;
               live_loaded[r.depth_index] = 1'b1;
            end
         end
         dspp_pkg::CMD_LOAD_BG: begin
            if (r.depth_index < DEPTH_N) begin
               bg_depth[r.depth_index] = r.depth_value;
               bg_loaded[r.depth_index] = 1'b1;
            end
         end
         dspp_pkg::CMD_RENDER: begin
            res = '0;
            delta = -1;
            if (map_point(r.screen_x, r.screen_y, idx, res.screen_index)) begin
               if (live_depth[idx] != 0 && bg_depth[idx] != 0)
                  delta = int'(bg_depth[idx]) - int'(live_depth[idx]);
            end
            if (delta >= DELTA_MIN && delta <= DELTA_MAX) begin
               res.grey = GREY_W'((delta - DELTA_MIN) * GREY_FULL / (DELTA_MAX - DELTA_MIN));
               res.written = 1'b1;
               painted_count++;
            end
            expected_paints.insert(expected_paints.size(), res);
         end
         default: ;
      endcase
   endtask

   task automatic push_request(input paint_request_type r);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      shade_request(r);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r.screen_y, r.screen_x, r.depth_value, r.depth_index};
      req_tuser  <= r.cmd;
      do @(posedge clock); while (!req_tready);
      if (r.cmd == dspp_pkg::CMD_RENDER) begin
         render_count++;
         phase_items++;
      end else if (r.cmd != CMD_UNUSED && r.depth_index < DEPTH_N) begin
         load_count++;
         phase_items++;
      end else begin
         ignored_count++;
      end
   endtask

   task automatic send_load(input dspp_pkg::cmd_type op, input logic [DIDX_W-1:0] idx,
                            input logic [DVAL_W-1:0] val);
      paint_request_type r;
      r.cmd = op;
      r.depth_index = idx;
      r.depth_value = val;
      r.screen_x = SCR_W'($urandom);
      r.screen_y = SCR_W'($urandom);
      push_request(r);
   endtask

   // loads whatever the render will read (all of it when forced), then renders
   task automatic load_and_render(input logic [SCR_W-1:0] x, input logic [SCR_W-1:0] y,
                                  input bit force_load, input logic [DVAL_W-1:0] lv,
                                  input logic [DVAL_W-1:0] bv);
      paint_request_type r;
      logic [DIDX_W-1:0] idx;
      logic [SIDX_W-1:0] sidx;
      if (map_point(x, y, idx, sidx)) begin
         if (force_load || !live_loaded[idx])
            send_load(dspp_pkg::CMD_LOAD_LIVE, idx, lv);
         if (force_load || !bg_loaded[idx])
            send_load(dspp_pkg::CMD_LOAD_BG, idx, bv);
      end
      r.cmd = dspp_pkg::CMD_RENDER;
      r.depth_index = DIDX_W'($urandom);
      r.depth_value = DVAL_W'($urandom);
      r.screen_x = x;
      r.screen_y = y;
      push_request(r);
      recent_pixels.insert(recent_pixels.size(), screen_pixel_type'({x, y}));
      if (recent_pixels.size() > 32)
         void'(recent_pixels.pop_front());
   endtask

   task automatic pick_depths(output logic [DVAL_W-1:0] lv, output logic [DVAL_W-1:0] bv);
      int r, d;
      r = $urandom_range(0, 15);
      bv = DVAL_W'($urandom_range(200, 65000));
      d = (r == 5) ? -int'($urandom_range(0, 200)) : int'($urandom_range(24, 156));
      lv = DVAL_W'(int'(bv) - d);
      case (r)
         0: lv = '0;
         1: bv = '0;
         2, 3: begin
            lv = DVAL_W'($urandom);
            bv = DVAL_W'($urandom);
         end
         4: begin
            bv = '1;
            lv = DVAL_W'(65535 - $urandom_range(25, 155));
         end
         default: ;
      endcase
   endtask

   task automatic random_pixel(output logic [SCR_W-1:0] x, output logic [SCR_W-1:0] y);
      x = SCR_W'($urandom_range(0, 1023));
      y = ($urandom_range(0, 7) == 0) ? SCR_W'($urandom_range(768, 1023))
                                      : SCR_W'($urandom_range(0, 767));
      if ($urandom_range(0, 15) == 0)
         x = $urandom_range(0, 1) ? '1 : '0;
   endtask

   // stop sending and wait until the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_paints.size() != 0)
         @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
   endtask

   task automatic csr_write(input dspp_pkg::reg_index_type idx,
                            input dspp_pkg::coord_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_corners(input dspp_pkg::corner_set_type c);
      drain();
      csr_write(dspp_pkg::REG_C0_X, c.x[0]);
      csr_write(dspp_pkg::REG_C0_Y, c.y[0]);
      csr_write(dspp_pkg::REG_C1_X, c.x[1]);
      csr_write(dspp_pkg::REG_C1_Y, c.y[1]);
      csr_write(dspp_pkg::REG_C2_X, c.x[2]);
      csr_write(dspp_pkg::REG_C2_Y, c.y[2]);
      csr_write(dspp_pkg::REG_C3_X, c.x[3]);
      csr_write(dspp_pkg::REG_C3_Y, c.y[3]);
      csr_valid <= 1'b0;
      warp_corners = c;
      quad_count++;
   endtask

   function automatic dspp_pkg::corner_set_type random_quad(input int xlo, input int xhi,
                                                            input int ylo, input int yhi);
      dspp_pkg::corner_set_type c;
      for (int k = 0; k < 4; k++) begin
         c.x[k] = dspp_pkg::coord_type'(xlo + int'($urandom_range(0, xhi - xlo)));
         c.y[k] = dspp_pkg::coord_type'(ylo + int'($urandom_range(0, yhi - ylo)));
      end
      return c;
   endfunction

   function automatic dspp_pkg::corner_set_type extreme_quad();
      dspp_pkg::corner_set_type c;
      c = random_quad(-2048, 2047, -2048, 2047);
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 2) != 0)
            c.x[k] = $urandom_range(0, 1) ? dspp_pkg::coord_type'(2047)
                                          : dspp_pkg::coord_type'(-2048);
         if ($urandom_range(0, 2) != 0)
            c.y[k] = $urandom_range(0, 1) ? dspp_pkg::coord_type'(2047)
                                          : dspp_pkg::coord_type'(-2048);
      end
      return c;
   endfunction

   task automatic test_grey_ramp();
      load_and_render(10'd0, 10'd0, 1'b1, 16'd65385, 16'd65535);
      load_and_render(10'd1023, 10'd767, 1'b1, 16'd1, 16'd31);
      load_and_render(10'd300, 10'd400, 1'b1, 16'd1000, 16'd1029);
      load_and_render(10'd700, 10'd100, 1'b1, 16'd1000, 16'd1151);
   endtask

   task automatic test_zero_depth_and_saturation();
      load_and_render(10'd512, 10'd1023, 1'b1, 16'd0, 16'd100);
      load_and_render(10'd640, 10'd10, 1'b1, 16'd500, 16'd0);
   endtask

   task automatic test_ignored_requests();
      paint_request_type r;
      send_load(dspp_pkg::CMD_LOAD_LIVE, '1, '1);
      r = '1;
      r.cmd = CMD_UNUSED;
      push_request(r);
      load_and_render(10'd0, 10'd0, 1'b0, 16'd0, 16'd0);
   endtask

   task automatic test_outside_frame();
      dspp_pkg::corner_set_type c;
      c.x[0] = dspp_pkg::coord_type'(-2048);
      c.y[0] = dspp_pkg::coord_type'(-2048);
      c.x[1] = dspp_pkg::coord_type'(2047);
      c.y[1] = dspp_pkg::coord_type'(-2048);
      c.x[2] = dspp_pkg::coord_type'(2047);
      c.y[2] = dspp_pkg::coord_type'(2047);
      c.x[3] = dspp_pkg::coord_type'(-2048);
      c.y[3] = dspp_pkg::coord_type'(2047);
      set_corners(c);
      load_and_render(10'd0, 10'd0, 1'b0, 16'd0, 16'd0);
      load_and_render(10'd1023, 10'd0, 1'b0, 16'd0, 16'd0);
      load_and_render(10'd1023, 10'd767, 1'b0, 16'd0, 16'd0);
      load_and_render(10'd0, 10'd767, 1'b0, 16'd0, 16'd0);
      // centre blends to -0.5, which truncates onto depth pixel 0
      load_and_render(10'd512, 10'd384, 1'b1, 16'd2000, 16'd2100);
   endtask

   task automatic test_random_warp(input dspp_pkg::corner_set_type c, input bit quiet);
      paint_request_type r;
      screen_pixel_type p;
      logic [SCR_W-1:0] x, y;
      logic [DVAL_W-1:0] lv, bv;
      int pick, loops;
      set_corners(c);
      phase_items = 0;
      loops = 0;
      while (phase_items < PHASE_ITEMS) begin
         if (loops % 64 == 0) begin
            sender_gaps = !quiet && $urandom_range(0, 3) != 0;
            receiver_stalls = !quiet && $urandom_range(0, 3) != 0;
         end
         loops++;
         pick = $urandom_range(0, 99);
         pick_depths(lv, bv);
         if (pick < 55 || recent_pixels.size() == 0) begin
            random_pixel(x, y);
            load_and_render(x, y, $urandom_range(0, 3) == 0, lv, bv);
         end else if (pick < 85) begin
            p = recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
            load_and_render(p.x, p.y, pick >= 75, lv, bv);
         end else if (pick < 93) begin
            send_load($urandom_range(0, 1) ? dspp_pkg::CMD_LOAD_BG : dspp_pkg::CMD_LOAD_LIVE,
                      DIDX_W'($urandom_range(0, DEPTH_N - 1)), lv);
         end else begin
            r = paint_request_type'(REQ_BITS'({$urandom, $urandom}));
            if ($urandom_range(0, 1)) begin
               r.cmd = CMD_UNUSED;
            end else begin
               r.cmd = dspp_pkg::CMD_LOAD_LIVE;
               r.depth_index = DIDX_W'($urandom_range(DEPTH_N, 2 ** DIDX_W - 1));
            end
            push_request(r);
            if ($urandom_range(0, 7) == 0)
               drain();
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = idle_length() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      paint_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_paints.size() == 0) begin
            $error("result with no request pending: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = expected_paints.pop_front();
            if (rsp_tdata[GREY_W-1:0] !== want.grey) begin
               $error("pixel_value expected %0d got %0d", want.grey, rsp_tdata[GREY_W-1:0]);
               failures++;
            end
            if (rsp_tuser !== want.written) begin
               $error("pixel_written expected %0d got %0d", want.written, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[GREY_W+SIDX_W-1:GREY_W] !== want.screen_index) begin
               $error("screen_index expected %0d got %0d", want.screen_index,
                      rsp_tdata[GREY_W+SIDX_W-1:GREY_W]);
               failures++;
            end
            if (rsp_tdata[RSP_DATA_W-1:GREY_W+SIDX_W] !== '0) begin
               $error("tdata padding expected 0 got %h", rsp_tdata[RSP_DATA_W-1:GREY_W+SIDX_W]);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[depth_surface_paint_pixel_core] ERROR");
         $finish;
      end
   end

   initial begin
      dspp_pkg::corner_set_type flipped;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_grey_ramp();
      test_zero_depth_and_saturation();
      test_ignored_requests();
      test_outside_frame();

      flipped.x[0] = dspp_pkg::coord_type'(639);
      flipped.y[0] = dspp_pkg::coord_type'(479);
      flipped.x[1] = dspp_pkg::coord_type'(0);
      flipped.y[1] = dspp_pkg::coord_type'(479);
      flipped.x[2] = dspp_pkg::coord_type'(0);
      flipped.y[2] = dspp_pkg::coord_type'(0);
      flipped.x[3] = dspp_pkg::coord_type'(639);
      flipped.y[3] = dspp_pkg::coord_type'(0);

      test_random_warp(dspp_pkg::CORNER_RESET, 1'b0);
      test_random_warp(random_quad(-80, 719, -60, 539), 1'b0);
      test_random_warp(random_quad(0, 15, 0, 11), 1'b0);
      test_random_warp(flipped, 1'b0);
      test_random_warp(extreme_quad(), 1'b0);
      test_random_warp(random_quad(-700, 1300, -500, 1000), 1'b0);
      test_random_warp(dspp_pkg::CORNER_RESET, 1'b1);
      drain();

      $display("Covered %0d renders (%0d painted), %0d depth loads and %0d ignored requests",
               render_count, painted_count, load_count, ignored_count);
      $display("over %0d corner quads with random gaps and result back-pressure", quad_count);
      if (failures == 0)
         $display("[depth_surface_paint_pixel_core] OK");
      else
         $display("[depth_surface_paint_pixel_core] ERROR");
      $finish;
   end

endmodule
